// File: sv/stmc_pkg.sv
// ---------------------------------------------------------------------------
// stmc_pkg
// Types and constants shared by the stall timeout mode controller.
// ---------------------------------------------------------------------------
`default_nettype none

package stmc_pkg;

  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_INDEX_BITS = 1;

  localparam logic [31:0]       STALL_TIMEOUT_RESET = 32'd60;
  localparam logic signed [7:0] LOW_PRIO_RESET      = 8'sd6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STALL_TIMEOUT = 1'b0,
    REG_LOW_PRIO      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_FETCHED    = 3'd1,
    OP_TERMINATED = 3'd2,
    OP_SCHED_FAIL = 3'd3,
    OP_CRASH      = 3'd4,
    OP_NEW_BLOCK  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_WARM_UP    = 2'd0,
    MODE_WAIT_NEW   = 2'd1,
    MODE_WAIT_SCHED = 2'd2,
    MODE_WAIT_EXEC  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DISABLE = 2'd1,
    ACT_ENABLE  = 2'd2
  } action_t;

  typedef struct packed {
    logic [31:0]       stall_timeout;
    logic signed [7:0] low_priority_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [31:0]       now_seconds;
    logic signed [7:0] fetched_priority;
    logic              source_available;
    logic              top_present;
    logic signed [7:0] top_priority;
    logic              any_pending;
  } event_t;

  typedef struct packed {
    action_t enable_action;
    mode_t   mode_now;
    logic    sequence_error;
  } result_t;

endpackage

`default_nettype wire

// File: sv/stmc_if.sv
// ---------------------------------------------------------------------------
// stmc_if
// Valid/ready channels for events into and results out of the controller.
// ---------------------------------------------------------------------------
`default_nettype none

interface stmc_event_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [31:0]       now_seconds;
  logic signed [7:0] fetched_priority;
  logic              source_available;
  logic              top_present;
  logic signed [7:0] top_priority;
  logic              any_pending;

  modport source (
    output valid, opcode, now_seconds, fetched_priority, source_available,
           top_present, top_priority, any_pending,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_seconds, fetched_priority, source_available,
           top_present, top_priority, any_pending,
    output ready
  );
endinterface

interface stmc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] enable_action;
  logic [1:0] mode_now;
  logic       sequence_error;

  modport source (output valid, enable_action, mode_now, sequence_error, input ready);
  modport sink   (input valid, enable_action, mode_now, sequence_error, output ready);
endinterface

`default_nettype wire

// File: sv/stmc_cfg_regs.sv
// ---------------------------------------------------------------------------
// stmc_cfg_regs
// Configuration registers: stall timeout and low priority threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module stmc_cfg_regs
  import stmc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_timeout          <= STALL_TIMEOUT_RESET;
      cfg.low_priority_threshold <= LOW_PRIO_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STALL_TIMEOUT: cfg.stall_timeout <= cfg_wdata[31:0];
        REG_LOW_PRIO:      cfg.low_priority_threshold <= $signed(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/stmc_core.sv
// ---------------------------------------------------------------------------
// stmc_core
// Mode register, event timestamps and the per-event decision logic.
// ---------------------------------------------------------------------------
`default_nettype none

module stmc_core
  import stmc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  event_t    item,
  input  cfg_t      cfg,
  output result_t   res
);

  localparam int unsigned CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  mode_t                mode, mode_next;
  logic [TIME_BITS-1:0] last_coverage_time, last_coverage_time_next;
  logic [TIME_BITS-1:0] last_crash_time, last_crash_time_next;
  logic [TIME_BITS-1:0] last_high_fetch_time, last_high_fetch_time_next;
  logic [TIME_BITS-1:0] last_fetch_time, last_fetch_time_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] d_cov, d_crash, d_high, d_fetch;
  logic [CMP_BITS-1:0]  timeout_ext;
  logic                 blocks, crashes, hp, fetch_recent;
  logic                 top_high;
  action_t              act;
  logic                 err;

  assign now_t       = TIME_BITS'(item.now_seconds);
  assign timeout_ext = CMP_BITS'(cfg.stall_timeout);

  // wrap-around elapsed times
  assign d_cov   = now_t - last_coverage_time;
  assign d_crash = now_t - last_crash_time;
  assign d_high  = now_t - last_high_fetch_time;
  assign d_fetch = now_t - last_fetch_time;

  assign blocks       = CMP_BITS'(d_cov) < timeout_ext;
  assign crashes      = CMP_BITS'(d_crash) < timeout_ext;
  assign hp           = CMP_BITS'(d_high) < timeout_ext;
  assign fetch_recent = CMP_BITS'(d_fetch) < timeout_ext;

  assign top_high = item.top_present &&
                    ($signed(item.top_priority) > $signed(cfg.low_priority_threshold));

  always_comb begin
    mode_next                 = mode;
    last_coverage_time_next   = last_coverage_time;
    last_crash_time_next      = last_crash_time;
    last_high_fetch_time_next = last_high_fetch_time;
    last_fetch_time_next      = last_fetch_time;
    act                       = ACT_NONE;
    err                       = 1'b0;
    unique case (opcode_t'(item.opcode))
      OP_TICK: begin
        if (item.source_available) begin
          unique case (mode)
            MODE_WARM_UP: begin
              if (!blocks && !crashes) mode_next = MODE_WAIT_NEW;
              else act = ACT_DISABLE;
            end
            MODE_WAIT_NEW: begin
              if ((top_high && !hp) || (!blocks && !crashes && item.any_pending)) begin
                act       = ACT_ENABLE;
                mode_next = MODE_WAIT_SCHED;
              end else begin
                act = ACT_DISABLE;
              end
            end
            MODE_WAIT_EXEC: begin
              if (!fetch_recent) mode_next = MODE_WAIT_NEW;
            end
            MODE_WAIT_SCHED: ;
            default: ;
          endcase
        end
      end
      OP_FETCHED: begin
        err                  = (mode != MODE_WAIT_SCHED);
        mode_next            = MODE_WAIT_EXEC;
        act                  = ACT_DISABLE;
        last_fetch_time_next = now_t;
        // strictly positive priority counts as a high priority fetch
        if (!item.fetched_priority[7] && (item.fetched_priority != 8'sd0)) begin
          last_high_fetch_time_next = now_t;
        end
      end
      OP_SCHED_FAIL: begin
        err       = (mode != MODE_WAIT_SCHED);
        mode_next = MODE_WAIT_NEW;
      end
      OP_CRASH:      last_crash_time_next = now_t;
      OP_NEW_BLOCK:  last_coverage_time_next = now_t;
      OP_TERMINATED: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= MODE_WARM_UP;
      last_coverage_time   <= '0;
      last_crash_time      <= '0;
      last_high_fetch_time <= '0;
      last_fetch_time      <= '0;
    end else if (fire) begin
      mode                 <= mode_next;
      last_coverage_time   <= last_coverage_time_next;
      last_crash_time      <= last_crash_time_next;
      last_high_fetch_time <= last_high_fetch_time_next;
      last_fetch_time      <= last_fetch_time_next;
    end
  end

  assign res.enable_action  = act;
  assign res.mode_now       = mode_next;
  assign res.sequence_error = err;

endmodule

`default_nettype wire

// File: sv/stall_timeout_mode_controller_top.sv
// ---------------------------------------------------------------------------
// stall_timeout_mode_controller_top
// Four-mode controller that decides when to enable injection of extra work.
// ---------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   events    in   valid/ready    opcode, now_seconds, priorities, flags
//   results   out  valid/ready    enable_action, mode_now, sequence_error
//   cfg       in   cfg_wen        cfg_index, cfg_wdata
//
// one event per cycle sustained while results are accepted; an event goes from its transaction
// through the input register, then the result register, to result valid.
// the decision logic is four subtract-compares and the mode update.
// rst is synchronous: mode warm up, timestamps zero, registers to defaults.
// a stalled result holds while an empty input register still takes one event.
// ---------------------------------------------------------------------------
`default_nettype none

module stall_timeout_mode_controller_top
  import stmc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  stmc_event_if.sink                     events,
  stmc_result_if.source                  results
);

  cfg_t    cfg;
  event_t  in_item;
  logic    in_valid;
  result_t core_res;
  result_t out_res;
  logic    out_valid;
  logic    fire;

  assign fire         = in_valid && (!out_valid || results.ready);
  assign events.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (events.ready) in_valid <= events.valid;
      if (!out_valid || results.ready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      in_item.opcode           <= events.opcode;
      in_item.now_seconds      <= events.now_seconds;
      in_item.fetched_priority <= events.fetched_priority;
      in_item.source_available <= events.source_available;
      in_item.top_present      <= events.top_present;
      in_item.top_priority     <= events.top_priority;
      in_item.any_pending      <= events.any_pending;
    end
    if (fire) out_res <= core_res;
  end

  stmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stmc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  assign results.valid          = out_valid;
  assign results.enable_action  = out_res.enable_action;
  assign results.mode_now       = out_res.mode_now;
  assign results.sequence_error = out_res.sequence_error;

endmodule

`default_nettype wire
